// ===== hdl/spn_pkg.sv =====
// Shared types and constants of the spectrum peak normalizer.
// Holds the item record, the configuration record and the register map.
// Depends on nothing; every other file of the block imports it.
package spn_pkg;

	localparam int NUM_BINS    = 128;
	localparam int BIN_AW      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int DATA_W      = 16;
	localparam int BIN_W       = 7;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [DATA_W-1:0] SMOOTH_W_RESET   = 16'd6554;
	localparam logic [DATA_W-1:0] PEAK_FLOOR_RESET = 16'd1;

	typedef enum logic {
		REG_SMOOTHING_WEIGHT = 1'b0,
		REG_PEAK_FLOOR       = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] smoothing_weight;
		logic [DATA_W-1:0] peak_floor;
	} cfg_t;

	typedef struct packed {
		logic [DATA_W-1:0] magnitude;
		logic [BIN_W-1:0]  bin;
		logic [DATA_W-1:0] frame_delta;
		logic [DATA_W-1:0] envelope;
		logic              last;
		logic              in_range;
	} item_t;

endpackage

// ===== hdl/spectrum_peak_normalizer.sv =====
// Spectrum peak normalizer, top level: joins the register port, front end and back end.
// Depends on spn_pkg, spn_csr, spn_front and spn_back.
//
// Each item is one spectrum bin: its magnitude, bin index, frame time step, envelope
// level and an end-of-frame mark. For every item the block returns exactly one
// result: the bin's new smoothed, peak-normalized level in Q0.16, with the bin
// index and the end-of-frame mark echoed. Per bin it keeps a running peak and a
// smoothed value; the peak first rises to the magnitude, the ratio magnitude/peak
// is blended in by the smoothing weight, then the peak decays toward the floor by
// frame_delta*envelope, or drops onto the floor when the envelope is zero. Bins at
// or beyond the store depth produce a level of zero and leave the stores alone.
// The block takes one item per clock unless the output stalls or the head item's
// bin is still being updated. A result passes the store read, the eight-stage
// divider that forms the ratio, the blend multiply and the output register. The
// front end queues up to four items, so input keeps flowing while a result waits
// to be taken. An item for a bin that is still being updated by an earlier item
// waits at the head of the queue until that item reaches the output register.
// Both stores read as their reset values right after reset, with no clearing
// pass. The smoothing weight and peak floor are written through the APB port at
// byte addresses 0 and 4; the user must write them only while the block is idle,
// which the block does not enforce. A new floor does not alter the stored peaks.
module spectrum_peak_normalizer import spn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_W-1:0]     magnitude,
	input  logic [BIN_W-1:0]      bin_index,
	input  logic [DATA_W-1:0]     frame_delta,
	input  logic [DATA_W-1:0]     envelope,
	input  logic                  last_bin,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_W-1:0]     smoothed_level,
	output logic [BIN_W-1:0]      bin_number,
	output logic                  frame_end
);

	cfg_t  cfg;
	logic  head_valid;
	item_t head;
	logic  pop;

	// Register file; the values feed the back end directly.
	spn_csr u_csr (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front end: accepts an item whenever the queue has room.
	spn_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.magnitude   (magnitude),
		.bin_index   (bin_index),
		.frame_delta (frame_delta),
		.envelope    (envelope),
		.last_bin    (last_bin),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop)
	);

	// Back end: pops the queue head when the bin is free and the pipeline moves.
	spn_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_level (smoothed_level),
		.bin_number     (bin_number),
		.frame_end      (frame_end)
	);

`ifndef SYNTHESIS
	// The back end only takes an item that the queue actually holds.
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("back end popped an empty queue");

	// A queue that refuses input must have an item waiting at its head.
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> head_valid)
		else $error("input stalled with no item queued");

	// The peak floor changes only through a register write.
	a_floor_by_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.peak_floor != $past(cfg.peak_floor)) |->
		$past(psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_PEAK_FLOOR)))
		else $error("peak floor changed without a write");
`endif

endmodule

// ===== hdl/spn_csr.sv =====
// Configuration registers of the spectrum peak normalizer behind an APB-style port.
// Holds the smoothing weight and the peak floor; depends on spn_pkg.
module spn_csr import spn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	// Registers sit on 4-byte steps, so the top address bit picks one.
	assign sel    = reg_idx_t'(paddr[APB_ADDR_W-1]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_weight <= SMOOTH_W_RESET;
			cfg_q.peak_floor       <= PEAK_FLOOR_RESET;
		end else if (wr_en) begin
			case (sel)
				REG_SMOOTHING_WEIGHT: cfg_q.smoothing_weight <= pwdata[DATA_W-1:0];
				REG_PEAK_FLOOR:       cfg_q.peak_floor       <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_SMOOTHING_WEIGHT: prdata = APB_DATA_W'(cfg_q.smoothing_weight);
			REG_PEAK_FLOOR:       prdata = APB_DATA_W'(cfg_q.peak_floor);
			default:              prdata = '0;
		endcase
	end

endmodule

// ===== hdl/spn_front.sv =====
// Front end of the spectrum peak normalizer: accepts items, checks the bin range
// and queues them for the back end. Depends on spn_pkg.
module spn_front import spn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] magnitude,
	input  logic [BIN_W-1:0]  bin_index,
	input  logic [DATA_W-1:0] frame_delta,
	input  logic [DATA_W-1:0] envelope,
	input  logic              last_bin,
	output logic              head_valid,
	output item_t             head,
	input  logic              pop
);

	item_t             fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	item_t             in_item;
	logic              push;

	// Items for bins beyond the store are marked here and later produce a level of zero, leaving the stores alone.
	always_comb begin
		in_item.magnitude   = magnitude;
		in_item.bin         = bin_index;
		in_item.frame_delta = frame_delta;
		in_item.envelope    = envelope;
		in_item.last        = last_bin;
		in_item.in_range    = (32'(bin_index) < 32'(NUM_BINS));
	end

	assign in_ready   = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != '0);
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// ===== hdl/spn_back.sv =====
// Back end of the spectrum peak normalizer: bin stores, peak decay, pipelined
// divider, smoothing blend and the output register. Depends on spn_pkg.
module spn_back import spn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              head_valid,
	input  item_t             head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] smoothed_level,
	output logic [BIN_W-1:0]  bin_number,
	output logic              frame_end
);

	localparam int DIV_STAGES = 8;
	localparam int DIV_BITS   = DATA_W / DIV_STAGES;
	localparam int LAST_STAGE = DIV_STAGES + 3;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int MIX_W      = 2 * DATA_W + 2;
	localparam int ACC_W      = 2 * DATA_W + 3;

	typedef struct packed {
		logic [BIN_W-1:0] bin;
		logic             last;
		logic             in_range;
	} tag_t;

	typedef struct packed {
		tag_t              tag;
		logic [DATA_W-1:0] sm;
		logic [DATA_W-1:0] divisor;
		logic              ratio_zero;
		logic              ratio_sat;
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] quo;
	} lane_t;

	// Restoring division, two quotient bits per stage.
	function automatic lane_t div_step(lane_t l);
		lane_t             r;
		logic [DATA_W:0]   t;
		r = l;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r.rem, 1'b0};
			if (t >= {1'b0, r.divisor}) begin
				t     = t - {1'b0, r.divisor};
				r.quo = {r.quo[DATA_W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[DATA_W-2:0], 1'b0};
			end
			r.rem = t[DATA_W-1:0];
		end
		return r;
	endfunction

	// Bin stores; an entry never written reads as its reset value.
	logic [DATA_W-1:0]   peak_mem [NUM_BINS];
	logic [DATA_W-1:0]   sm_mem   [NUM_BINS];
	logic [NUM_BINS-1:0] pk_vld_q;
	logic [NUM_BINS-1:0] sm_vld_q;

	logic                adv;
	logic                hazard;
	logic                issue;
	logic [BIN_AW-1:0]   head_addr;
	tag_t                head_tag;
	logic [LAST_STAGE:1] vld_s;

	// Stage 1: store read data.
	tag_t              tag_s1;
	logic [DATA_W-1:0] mag_s1;
	logic [DATA_W-1:0] dt_s1;
	logic [DATA_W-1:0] env_s1;
	logic [DATA_W-1:0] peak_rd_s1;
	logic [DATA_W-1:0] sm_rd_s1;
	logic              peak_hit_s1;
	logic              sm_hit_s1;

	// Stages 2 to DIV_STAGES+2: divider lanes, element k is stage k+2.
	lane_t             dlane_s [DIV_STAGES+1];
	lane_t             lane_in;
	logic [DATA_W-1:0] peak_cur;
	logic [DATA_W-1:0] peak_max;

	// Decay path alongside the divider.
	logic [PROD_W-1:0] alpha_prod;
	logic [PROD_W-1:0] alpha_prod_s2;
	logic              env_zero_s2;
	logic [PROD_W:0]   alpha_sum;
	logic              up;
	logic [DATA_W-1:0] gap;
	logic [DATA_W-1:0] alpha_s3;
	logic [DATA_W-1:0] gap_s3;
	logic              up_s3;
	logic              env_zero_s3;
	logic [PROD_W-1:0] step_prod_s4;
	logic              up_s4;
	logic              env_zero_s4;
	logic [PROD_W:0]   step_sum;
	logic [DATA_W-1:0] step;
	logic [DATA_W-1:0] new_peak;
	logic              pk_wr;
	logic [BIN_AW-1:0] pk_addr;

	// Blend stage.
	logic [DATA_W-1:0]       ratio;
	logic signed [DATA_W:0]  diff;
	logic signed [MIX_W-1:0] mix_prod;
	tag_t                    tag_s11;
	logic [DATA_W-1:0]       sm_s11;
	logic signed [MIX_W-1:0] mix_prod_s11;
	logic signed [ACC_W-1:0] acc;
	logic [DATA_W-1:0]       level_next;
	logic                    sm_wr;
	logic [BIN_AW-1:0]       sm_addr;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] level_q;
	logic [BIN_W-1:0]  bin_q;
	logic              last_q;

	assign adv       = !out_valid_q || out_ready;
	assign head_addr = BIN_AW'(head.bin);

	always_comb begin
		head_tag.bin      = head.bin;
		head_tag.last     = head.last;
		head_tag.in_range = head.in_range;
	end

	// An item may not read a bin whose stores an earlier item has yet to write.
	always_comb begin
		hazard = 1'b0;
		if (vld_s[1] && tag_s1.in_range && (tag_s1.bin == head.bin)) begin
			hazard = 1'b1;
		end
		for (int k = 0; k <= DIV_STAGES; k++) begin
			if (vld_s[k+2] && dlane_s[k].tag.in_range && (dlane_s[k].tag.bin == head.bin)) begin
				hazard = 1'b1;
			end
		end
		if (vld_s[LAST_STAGE] && tag_s11.in_range && (tag_s11.bin == head.bin)) begin
			hazard = 1'b1;
		end
	end

	assign issue = head_valid && adv && !(hazard && head.in_range);
	assign pop   = issue;

	// Stage 1 to 2: peak rises to the magnitude, ratio special cases, dt*envelope.
	always_comb begin
		peak_cur   = peak_hit_s1 ? peak_rd_s1 : PEAK_FLOOR_RESET;
		peak_max   = (mag_s1 > peak_cur) ? mag_s1 : peak_cur;
		alpha_prod = dt_s1 * env_s1;
		lane_in.tag        = tag_s1;
		lane_in.sm         = sm_hit_s1 ? sm_rd_s1 : '0;
		lane_in.divisor    = peak_max;
		lane_in.ratio_zero = (peak_max == '0);
		lane_in.ratio_sat  = (mag_s1 == peak_max);
		lane_in.rem        = mag_s1;
		lane_in.quo        = '0;
	end

	// Stage 2 to 3: rounded decay fraction and distance to the floor.
	always_comb begin
		alpha_sum = {1'b0, alpha_prod_s2} + (PROD_W+1)'(32768);
		up        = (dlane_s[0].divisor < cfg.peak_floor);
		gap       = up ? (cfg.peak_floor - dlane_s[0].divisor)
		               : (dlane_s[0].divisor - cfg.peak_floor);
	end

	// Stage 4: new peak, written back to the peak store.
	always_comb begin
		step_sum = {1'b0, step_prod_s4} + (PROD_W+1)'(32768);
		step     = step_sum[PROD_W-1:DATA_W];
		if (env_zero_s4) begin
			new_peak = cfg.peak_floor;
		end else if (up_s4) begin
			new_peak = dlane_s[2].divisor + step;
		end else begin
			new_peak = dlane_s[2].divisor - step;
		end
		pk_wr   = adv && vld_s[4] && dlane_s[2].tag.in_range;
		pk_addr = BIN_AW'(dlane_s[2].tag.bin);
	end

	// Last divider stage to stage 11: ratio and weighted difference.
	always_comb begin
		if (dlane_s[DIV_STAGES].ratio_zero) begin
			ratio = '0;
		end else if (dlane_s[DIV_STAGES].ratio_sat) begin
			ratio = '1;
		end else begin
			ratio = dlane_s[DIV_STAGES].quo;
		end
		diff     = $signed({1'b0, ratio}) - $signed({1'b0, dlane_s[DIV_STAGES].sm});
		mix_prod = diff * $signed({1'b0, cfg.smoothing_weight});
	end

	// Stage 11 to output: sm + (ratio - sm) * w, rounded.
	always_comb begin
		acc = $signed({3'b000, sm_s11, {DATA_W{1'b0}}}) + ACC_W'(mix_prod_s11)
		      + $signed(ACC_W'(32768));
		level_next = tag_s11.in_range ? acc[PROD_W-1:DATA_W] : '0;
		sm_wr      = adv && vld_s[LAST_STAGE] && tag_s11.in_range;
		sm_addr    = BIN_AW'(tag_s11.bin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
			pk_vld_q    <= '0;
			sm_vld_q    <= '0;
		end else if (adv) begin
			vld_s       <= {vld_s[LAST_STAGE-1:1], issue};
			out_valid_q <= vld_s[LAST_STAGE];
			if (pk_wr) begin
				pk_vld_q[pk_addr] <= 1'b1;
			end
			if (sm_wr) begin
				sm_vld_q[sm_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1      <= head_tag;
			mag_s1      <= head.magnitude;
			dt_s1       <= head.frame_delta;
			env_s1      <= head.envelope;
			peak_rd_s1  <= peak_mem[head_addr];
			sm_rd_s1    <= sm_mem[head_addr];
			peak_hit_s1 <= pk_vld_q[head_addr];
			sm_hit_s1   <= sm_vld_q[head_addr];

			dlane_s[0]    <= lane_in;
			alpha_prod_s2 <= alpha_prod;
			env_zero_s2   <= (env_s1 == '0);
			for (int k = 1; k <= DIV_STAGES; k++) begin
				dlane_s[k] <= div_step(dlane_s[k-1]);
			end

			alpha_s3    <= alpha_sum[PROD_W-1:DATA_W];
			gap_s3      <= gap;
			up_s3       <= up;
			env_zero_s3 <= env_zero_s2;

			step_prod_s4 <= gap_s3 * alpha_s3;
			up_s4        <= up_s3;
			env_zero_s4  <= env_zero_s3;

			tag_s11      <= dlane_s[DIV_STAGES].tag;
			sm_s11       <= dlane_s[DIV_STAGES].sm;
			mix_prod_s11 <= mix_prod;

			level_q <= level_next;
			bin_q   <= tag_s11.bin;
			last_q  <= tag_s11.last;
		end
	end

	always_ff @(posedge clk) begin
		if (pk_wr) begin
			peak_mem[pk_addr] <= new_peak;
		end
		if (sm_wr) begin
			sm_mem[sm_addr] <= level_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_level = level_q;
	assign bin_number     = bin_q;
	assign frame_end      = last_q;

endmodule
